// ----- rtl/trkd_pkg.sv -----
// Package: shared types, constants and the helper function of the touch ring knob decoder.
package trkd_pkg;

    localparam int COORD_WIDTH = 10;
    localparam int VAL_WIDTH   = 16;
    localparam int THR_WIDTH   = 8;
    localparam int TSTEP_WIDTH = 8;
    localparam int ASTEP_WIDTH = 10;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 10;

    typedef logic [COORD_WIDTH-1:0]      t_coord;
    typedef logic signed [VAL_WIDTH-1:0] t_value;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_INC  = 2'd1,
        EV_DEC  = 2'd2
    } t_event;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_AREA_LEFT   = 3'd0,
        CFG_AREA_RIGHT  = 3'd1,
        CFG_AREA_TOP    = 3'd2,
        CFG_AREA_BOTTOM = 3'd3,
        CFG_MOVE_THR    = 3'd4,
        CFG_TARGET_STEP = 3'd5,
        CFG_ANGLE_STEP  = 3'd6
    } t_cfg_idx;

    localparam t_coord               RST_AREA_LEFT   = t_coord'(0);
    localparam t_coord               RST_AREA_RIGHT  = t_coord'(240);
    localparam t_coord               RST_AREA_TOP    = t_coord'(0);
    localparam t_coord               RST_AREA_BOTTOM = t_coord'(240);
    localparam logic [THR_WIDTH-1:0]   RST_MOVE_THR    = THR_WIDTH'(10);
    localparam logic [TSTEP_WIDTH-1:0] RST_TARGET_STEP = TSTEP_WIDTH'(5);
    localparam logic [ASTEP_WIDTH-1:0] RST_ANGLE_STEP  = ASTEP_WIDTH'(30);

    typedef struct packed {
        t_coord                  area_left;
        t_coord                  area_right;
        t_coord                  area_top;
        t_coord                  area_bottom;
        logic [THR_WIDTH-1:0]    move_threshold;
        logic [TSTEP_WIDTH-1:0]  target_step;
        logic [ASTEP_WIDTH-1:0]  angle_step;
    } t_cfg;

    typedef struct packed {
        logic   pressed;
        t_coord touch_x;
        t_coord touch_y;
        t_value reported_target;
    } t_sample;

    typedef struct packed {
        t_event turn_dir;
        t_value working_target;
        t_value dial_position;
    } t_result;

    // clamp a 17-bit signed sum to the 16-bit signed range
    function automatic t_value sat16(input logic signed [VAL_WIDTH:0] v);
        t_value r;
        if (v[VAL_WIDTH] != v[VAL_WIDTH-1]) begin
            r = v[VAL_WIDTH] ? {1'b1, {(VAL_WIDTH-1){1'b0}}} : {1'b0, {(VAL_WIDTH-1){1'b1}}};
        end else begin
            r = v[VAL_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/touch_ring_knob_decoder_core.sv -----
// Top level of the touch ring knob decoder: input register, step logic, result register.
//
// Input channel: i_in_valid / o_in_stall carry one touch sample word (pressed,
// touch_x, touch_y, reported_target). A word is taken at a clock edge with
// i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result word (turn_dir,
// working_target, dial_position) for every input word, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 area_left .. 6 angle_step); other indexes are ignored. Write only when idle.
// An input word goes from the input register through the step logic into the
// result register, which drives the output.
// Throughput: one word per cycle when not stalled. The decode and saturating add
// sit in one stage between the input register and the result register; the state
// loop closes in that stage, so each word sees the state left by the word before it.
// Stall: while i_out_stall holds a full result register, the input register
// fills and o_in_stall rises; nothing is dropped.
// Reset (synchronous, active low): both registers empty, state cleared,
// configuration back to defaults.
module touch_ring_knob_decoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [trkd_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [trkd_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_pressed,
    input  logic [trkd_pkg::COORD_WIDTH-1:0]      i_touch_x,
    input  logic [trkd_pkg::COORD_WIDTH-1:0]      i_touch_y,
    input  logic signed [trkd_pkg::VAL_WIDTH-1:0] i_reported_target,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_turn_dir,
    output logic signed [trkd_pkg::VAL_WIDTH-1:0] o_working_target,
    output logic signed [trkd_pkg::VAL_WIDTH-1:0] o_dial_position
);
    import trkd_pkg::*;

    t_cfg    cfg;
    t_result step_res;
    logic    out_free;
    logic    advance;
    logic    in_take;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_result r_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    trkd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    trkd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_sample  (r_in),
        .i_advance (advance),
        .o_result  (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.pressed         <= i_pressed;
            r_in.touch_x         <= i_touch_x;
            r_in.touch_y         <= i_touch_y;
            r_in.reported_target <= i_reported_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_turn_dir       = r_out.turn_dir;
    assign o_working_target = r_out.working_target;
    assign o_dial_position  = r_out.dial_position;

endmodule

// ----- rtl/trkd_cfg.sv -----
// Configuration register file of the touch ring knob decoder.
module trkd_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [trkd_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [trkd_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    output trkd_pkg::t_cfg                        o_cfg
);
    import trkd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_AREA_LEFT:   n_cfg.area_left      = i_cfg_data[COORD_WIDTH-1:0];
                CFG_AREA_RIGHT:  n_cfg.area_right     = i_cfg_data[COORD_WIDTH-1:0];
                CFG_AREA_TOP:    n_cfg.area_top       = i_cfg_data[COORD_WIDTH-1:0];
                CFG_AREA_BOTTOM: n_cfg.area_bottom    = i_cfg_data[COORD_WIDTH-1:0];
                CFG_MOVE_THR:    n_cfg.move_threshold = i_cfg_data[THR_WIDTH-1:0];
                CFG_TARGET_STEP: n_cfg.target_step    = i_cfg_data[TSTEP_WIDTH-1:0];
                CFG_ANGLE_STEP:  n_cfg.angle_step     = i_cfg_data[ASTEP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_left      <= RST_AREA_LEFT;
            r_cfg.area_right     <= RST_AREA_RIGHT;
            r_cfg.area_top       <= RST_AREA_TOP;
            r_cfg.area_bottom    <= RST_AREA_BOTTOM;
            r_cfg.move_threshold <= RST_MOVE_THR;
            r_cfg.target_step    <= RST_TARGET_STEP;
            r_cfg.angle_step     <= RST_ANGLE_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/trkd_core.sv -----
// Decode state and single-pass step logic: touch decode, target sync, saturating update.
module trkd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trkd_pkg::t_cfg     i_cfg,
    input  trkd_pkg::t_sample  i_sample,
    input  logic               i_advance,
    output trkd_pkg::t_result  o_result
);
    import trkd_pkg::*;

    logic   r_released;
    t_coord r_anchor_x;
    t_coord r_anchor_y;
    t_value r_seen;
    t_value r_target;
    t_value r_angle;

    logic   n_released;
    t_coord n_anchor_x;
    t_coord n_anchor_y;
    t_value n_seen;
    t_value n_target;
    t_value n_angle;

    logic [COORD_WIDTH:0]   ax_hi, ay_hi, x_hi, y_hi;
    logic [COORD_WIDTH:0]   mid_v_sum, mid_h_sum;
    logic                   in_area, low_half, right_half;
    t_event                 ev;
    t_value                 base;
    logic signed [VAL_WIDTH:0] tgt_delta, ang_delta, tgt_sum, ang_sum;

    always_comb begin
        ax_hi     = {1'b0, r_anchor_x} + (COORD_WIDTH+1)'(i_cfg.move_threshold);
        ay_hi     = {1'b0, r_anchor_y} + (COORD_WIDTH+1)'(i_cfg.move_threshold);
        x_hi      = {1'b0, i_sample.touch_x} + (COORD_WIDTH+1)'(i_cfg.move_threshold);
        y_hi      = {1'b0, i_sample.touch_y} + (COORD_WIDTH+1)'(i_cfg.move_threshold);
        mid_v_sum = {1'b0, i_cfg.area_top} + {1'b0, i_cfg.area_bottom};
        mid_h_sum = {1'b0, i_cfg.area_left} + {1'b0, i_cfg.area_right};
        in_area   = (i_sample.touch_x > i_cfg.area_left) && (i_sample.touch_x < i_cfg.area_right)
                 && (i_sample.touch_y > i_cfg.area_top) && (i_sample.touch_y < i_cfg.area_bottom);
        low_half   = r_anchor_y > mid_v_sum[COORD_WIDTH:1];
        right_half = i_sample.touch_x > mid_h_sum[COORD_WIDTH:1];

        n_released = r_released;
        n_anchor_x = r_anchor_x;
        n_anchor_y = r_anchor_y;
        ev         = EV_NONE;

        if (!i_sample.pressed) begin
            n_released = 1'b1;
        end else if (r_released) begin
            n_released = 1'b0;
            n_anchor_x = i_sample.touch_x;
            n_anchor_y = i_sample.touch_y;
        end else begin
            if (in_area) begin
                if ({1'b0, i_sample.touch_x} > ax_hi) begin
                    ev = low_half ? EV_DEC : EV_INC;
                end else if (x_hi < {1'b0, r_anchor_x}) begin
                    ev = low_half ? EV_INC : EV_DEC;
                end
                // vertical motion overrides horizontal
                if ({1'b0, i_sample.touch_y} > ay_hi) begin
                    ev = right_half ? EV_INC : EV_DEC;
                end else if (y_hi < {1'b0, r_anchor_y}) begin
                    ev = right_half ? EV_DEC : EV_INC;
                end
            end
            if (ev != EV_NONE) begin
                n_anchor_x = i_sample.touch_x;
                n_anchor_y = i_sample.touch_y;
            end
        end

        // reload working target when the reported value changes
        n_seen = i_sample.reported_target;
        base   = (i_sample.reported_target != r_seen) ? i_sample.reported_target : r_target;

        tgt_delta = $signed({{(VAL_WIDTH+1-TSTEP_WIDTH){1'b0}}, i_cfg.target_step});
        ang_delta = $signed({{(VAL_WIDTH+1-ASTEP_WIDTH){1'b0}}, i_cfg.angle_step});
        tgt_sum   = {base[VAL_WIDTH-1], base};
        ang_sum   = {r_angle[VAL_WIDTH-1], r_angle};
        case (ev)
            EV_INC: begin
                tgt_sum = tgt_sum + tgt_delta;
                ang_sum = ang_sum + ang_delta;
            end
            EV_DEC: begin
                tgt_sum = tgt_sum - tgt_delta;
                ang_sum = ang_sum - ang_delta;
            end
            default: ;
        endcase
        n_target = sat16(tgt_sum);
        n_angle  = sat16(ang_sum);

        o_result.turn_dir       = ev;
        o_result.working_target = n_target;
        o_result.dial_position  = n_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_released <= 1'b0;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_seen     <= '0;
            r_target   <= '0;
            r_angle    <= '0;
        end else if (i_advance) begin
            r_released <= n_released;
            r_anchor_x <= n_anchor_x;
            r_anchor_y <= n_anchor_y;
            r_seen     <= n_seen;
            r_target   <= n_target;
            r_angle    <= n_angle;
        end
    end

endmodule

// ----- rtl/trkd_checker.sv -----
// Port-level checker of the touch ring knob decoder, bound to the top level.
module trkd_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic [1:0]                            o_turn_dir,
    input  logic signed [trkd_pkg::VAL_WIDTH-1:0] o_working_target,
    input  logic signed [trkd_pkg::VAL_WIDTH-1:0] o_dial_position
);
    import trkd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_turn_dir)
            && $stable(o_working_target) && $stable(o_dial_position)))
        else $error("stalled result word changed");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_turn_dir == EV_NONE || o_turn_dir == EV_INC
            || o_turn_dir == EV_DEC))
        else $error("bad turn direction code");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##2 o_out_valid)
        else $error("result word missing two cycles after input");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output can move");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result word without input word");

endmodule

bind touch_ring_knob_decoder_core trkd_checker u_trkd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_turn_dir       (o_turn_dir),
    .o_working_target (o_working_target),
    .o_dial_position  (o_dial_position)
);

// ----- sim/tb_touch_ring_knob_decoder_core.sv -----
// Testbench for touch_ring_knob_decoder_core: directed and random gestures checked against a knob turn model.
`timescale 1ns / 100ps

module tb_touch_ring_knob_decoder_core;

    import trkd_pkg::*;

    localparam int VAL_MAX   = 2 ** (VAL_WIDTH - 1) - 1;
    localparam int VAL_MIN   = -(2 ** (VAL_WIDTH - 1));
    localparam int COORD_MAX = 2 ** COORD_WIDTH - 1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_NO_REG = 3'd7;

    class knob_turn_model;
        t_cfg    cfg;
        logic    released;
        t_coord  anchor_x;
        t_coord  anchor_y;
        t_value  seen_report;
        t_value  target;
        t_value  angle;
        t_result pending_turns[$];
        int      errors;

        function new();
            cfg.area_left      = RST_AREA_LEFT;
            cfg.area_right     = RST_AREA_RIGHT;
            cfg.area_top       = RST_AREA_TOP;
            cfg.area_bottom    = RST_AREA_BOTTOM;
            cfg.move_threshold = RST_MOVE_THR;
            cfg.target_step    = RST_TARGET_STEP;
            cfg.angle_step     = RST_ANGLE_STEP;
            released    = 1'b0;
            anchor_x    = '0;
            anchor_y    = '0;
            seen_report = '0;
            target      = '0;
            angle       = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_AREA_LEFT:   cfg.area_left      = data[COORD_WIDTH-1:0];
                CFG_AREA_RIGHT:  cfg.area_right     = data[COORD_WIDTH-1:0];
                CFG_AREA_TOP:    cfg.area_top       = data[COORD_WIDTH-1:0];
                CFG_AREA_BOTTOM: cfg.area_bottom    = data[COORD_WIDTH-1:0];
                CFG_MOVE_THR:    cfg.move_threshold = data[THR_WIDTH-1:0];
                CFG_TARGET_STEP: cfg.target_step    = data[TSTEP_WIDTH-1:0];
                CFG_ANGLE_STEP:  cfg.angle_step     = data[ASTEP_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function t_value clamp_value(int v);
            if (v > VAL_MAX) return t_value'(VAL_MAX);
            if (v < VAL_MIN) return t_value'(VAL_MIN);
            return t_value'(v);
        endfunction

        function t_event decode_touch(logic pressed, t_coord x, t_coord y);
            t_event ev;
            int     ax;
            int     ay;
            int     th;
            bit     low_half;
            bit     right_half;
            ev = EV_NONE;
            ax = int'(anchor_x);
            ay = int'(anchor_y);
            th = int'(cfg.move_threshold);
            if (!pressed) begin
                released = 1'b1;
                return EV_NONE;
            end
            if (released) begin
                released = 1'b0;
                anchor_x = x;
                anchor_y = y;
                return EV_NONE;
            end
            if (x > cfg.area_left && x < cfg.area_right &&
                y > cfg.area_top && y < cfg.area_bottom) begin
                low_half   = ay > (int'(cfg.area_top) + int'(cfg.area_bottom)) / 2;
                right_half = int'(x) > (int'(cfg.area_left) + int'(cfg.area_right)) / 2;
                if (int'(x) > ax + th)
                    ev = low_half ? EV_DEC : EV_INC;
                else if (int'(x) < ax - th)
                    ev = low_half ? EV_INC : EV_DEC;
                // vertical motion wins
                if (int'(y) > ay + th)
                    ev = right_half ? EV_INC : EV_DEC;
                else if (int'(y) < ay - th)
                    ev = right_half ? EV_DEC : EV_INC;
            end
            if (ev != EV_NONE) begin
                anchor_x = x;
                anchor_y = y;
            end
            return ev;
        endfunction

        function void take_sample(logic pressed, t_coord x, t_coord y, t_value rep);
            t_event  ev;
            t_result turn;
            if (rep != seen_report) begin
                seen_report = rep;
                target      = rep;
            end
            ev = decode_touch(pressed, x, y);
            if (ev == EV_INC) begin
                target = clamp_value(int'(target) + int'(cfg.target_step));
                angle  = clamp_value(int'(angle) + int'(cfg.angle_step));
            end else if (ev == EV_DEC) begin
                target = clamp_value(int'(target) - int'(cfg.target_step));
                angle  = clamp_value(int'(angle) - int'(cfg.angle_step));
            end
            turn.turn_dir       = ev;
            turn.working_target = target;
            turn.dial_position  = angle;
            pending_turns.push_back(turn);
        endfunction

        function void check_turn(logic [1:0] ev, t_value wt, t_value dp);
            t_result want;
            if (pending_turns.size() == 0) begin
                $error("result word with no sample pending: turn_dir %0d", ev);
                errors++;
                return;
            end
            want = pending_turns.pop_front();
            if (ev !== want.turn_dir) begin
                $error("turn_dir: expected %0d, got %0d", want.turn_dir, ev);
                errors++;
            end
            if (wt !== want.working_target) begin
                $error("working_target: expected %0d, got %0d", want.working_target, wt);
                errors++;
            end
            if (dp !== want.dial_position) begin
                $error("dial_position: expected %0d, got %0d", want.dial_position, dp);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_pressed;
    t_coord                    i_touch_x;
    t_coord                    i_touch_y;
    t_value                    i_reported_target;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [1:0]                o_turn_dir;
    t_value                    o_working_target;
    t_value                    o_dial_position;

    knob_turn_model model = new();
    bit             calm = 1'b0;
    int unsigned    stall_left = 0;
    int             words_sent = 0;
    t_value         cur_report = '0;
    t_cfg           phase_cfg;

    touch_ring_knob_decoder_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pressed         (i_pressed),
        .i_touch_x         (i_touch_x),
        .i_touch_y         (i_touch_y),
        .i_reported_target (i_reported_target),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_turn_dir        (o_turn_dir),
        .o_working_target  (o_working_target),
        .o_dial_position   (o_dial_position)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_turn(o_turn_dir, o_working_target, o_dial_position);
        if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = pick_gap();
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(logic p, t_coord x, t_coord y, t_value rep);
        int unsigned gap;
        gap = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_pressed         <= p;
        i_touch_x         <= x;
        i_touch_y         <= y;
        i_reported_target <= rep;
        do @(posedge i_clk); while (o_in_stall);
        model.take_sample(p, x, y, rep);
        words_sent++;
    endtask

    task automatic send_num(int p, int x, int y, int rep);
        send_word(1'(p), t_coord'(x), t_coord'(y), t_value'(rep));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (model.pending_turns.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_word(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        model.write_reg(idx, data);
    endtask

    // upper data bits of the narrow registers get junk to check truncation
    task automatic apply_cfg(t_cfg c, bit stray);
        write_word(CFG_AREA_LEFT, c.area_left);
        write_word(CFG_AREA_RIGHT, c.area_right);
        write_word(CFG_AREA_TOP, c.area_top);
        write_word(CFG_AREA_BOTTOM, c.area_bottom);
        write_word(CFG_MOVE_THR, {2'($urandom_range(0, 3)), c.move_threshold});
        write_word(CFG_TARGET_STEP, {2'($urandom_range(0, 3)), c.target_step});
        write_word(CFG_ANGLE_STEP, c.angle_step);
        if (stray)
            write_word(CFG_NO_REG, CFG_DATA_WIDTH'($urandom_range(0, 1023)));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        int   lo;
        lo = $urandom_range(0, 700);
        c.area_left   = t_coord'(lo);
        c.area_right  = t_coord'($urandom_range(lo + 2, COORD_MAX));
        lo = $urandom_range(0, 700);
        c.area_top    = t_coord'(lo);
        c.area_bottom = t_coord'($urandom_range(lo + 2, COORD_MAX));
        c.move_threshold = ($urandom_range(0, 3) == 0) ? THR_WIDTH'($urandom_range(0, 255))
                                                       : THR_WIDTH'($urandom_range(0, 40));
        c.target_step = TSTEP_WIDTH'($urandom_range(0, 255));
        c.angle_step  = ASTEP_WIDTH'($urandom_range(0, 1023));
        return c;
    endfunction

    function automatic t_value pick_report();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return t_value'($urandom_range(0, 65535));
        if (r < 5) return t_value'(VAL_MAX - int'($urandom_range(0, 300)));
        if (r < 7) return t_value'(VAL_MIN + int'($urandom_range(0, 300)));
        return t_value'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic int pick_in_span(t_coord lo, t_coord hi);
        if (int'(hi) > int'(lo) + 1)
            return $urandom_range(int'(lo) + 1, int'(hi) - 1);
        return $urandom_range(0, COORD_MAX);
    endfunction

    function automatic int clip_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    task automatic play_gesture(int moves);
        int cx;
        int cy;
        int d;
        int th;
        int axis;
        th = int'(model.cfg.move_threshold);
        if ($urandom_range(0, 3) != 0)
            send_word(1'b0, t_coord'($urandom_range(0, COORD_MAX)),
                      t_coord'($urandom_range(0, COORD_MAX)), cur_report);
        cx = pick_in_span(model.cfg.area_left, model.cfg.area_right);
        cy = pick_in_span(model.cfg.area_top, model.cfg.area_bottom);
        send_word(1'b1, t_coord'(cx), t_coord'(cy), cur_report);
        for (int i = 0; i < moves; i++) begin
            if ($urandom_range(0, 29) == 0)
                cur_report = pick_report();
            if ($urandom_range(0, 9) == 0) begin
                send_word(1'($urandom_range(0, 1)), t_coord'($urandom_range(0, COORD_MAX)),
                          t_coord'($urandom_range(0, COORD_MAX)), cur_report);
            end else begin
                axis = $urandom_range(0, 2);
                if (axis != 1) begin
                    d  = $urandom_range(0, 2 * th + 6);
                    cx = clip_coord(cx + d - (th + 3));
                end
                if (axis != 0) begin
                    d  = $urandom_range(0, 2 * th + 6);
                    cy = clip_coord(cy + d - (th + 3));
                end
                send_word(1'b1, t_coord'(cx), t_coord'(cy), cur_report);
            end
        end
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            play_gesture($urandom_range(1, 12));
            if ($urandom_range(0, 99) == 0)
                wait_idle();
        end
    endtask

    task automatic run_directed();
        send_num(1, 100, 100, 0);
        send_num(0, 1023, 1023, 0);
        send_num(1, 60, 60, 0);
        send_num(1, 75, 60, 0);
        send_num(1, 60, 60, 0);
        send_num(1, 60, 80, 0);
        send_num(1, 200, 200, 0);
        send_num(1, 0, 120, 0);
        send_num(1, 240, 120, 0);
        send_num(1, 239, 239, 0);
        send_num(1, 1023, 1023, 0);
        // anchor near the origin: the minus-threshold test cannot fire
        send_num(0, 0, 0, 0);
        send_num(1, 5, 5, 0);
        send_num(1, 1, 1, 0);
        send_num(1, 1, 20, 0);
        // reload near the limits, then saturate
        send_num(0, 512, 512, 32760);
        send_num(1, 100, 100, 32760);
        send_num(1, 120, 100, 32760);
        send_num(1, 140, 100, 32760);
        send_num(1, 160, 100, 32760);
        send_num(0, 0, 0, -32766);
        send_num(1, 100, 100, -32766);
        send_num(1, 80, 100, -32766);
        send_num(1, 60, 100, -32766);
        send_num(1, 60, 60, -32766);
        cur_report = t_value'(-32766);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_pressed         = 1'b0;
        i_touch_x         = '0;
        i_touch_y         = '0;
        i_reported_target = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(250);
        wait_idle();

        // whole screen, zero threshold, widest steps
        phase_cfg = '{area_left: 0, area_right: 1023, area_top: 0, area_bottom: 1023,
                      move_threshold: 0, target_step: 255, angle_step: 1023};
        apply_cfg(phase_cfg, 1'b1);
        run_random(300);
        wait_idle();

        repeat (4) begin
            apply_cfg(random_cfg(), 1'($urandom_range(0, 1)));
            run_random(200);
            wait_idle();
        end

        // empty area, then inverted area
        phase_cfg = '{area_left: 300, area_right: 300, area_top: 0, area_bottom: 1023,
                      move_threshold: 3, target_step: 7, angle_step: 11};
        apply_cfg(phase_cfg, 1'b0);
        run_random(50);
        wait_idle();
        phase_cfg = '{area_left: 800, area_right: 100, area_top: 900, area_bottom: 50,
                      move_threshold: 3, target_step: 7, angle_step: 11};
        apply_cfg(phase_cfg, 1'b0);
        run_random(50);
        wait_idle();

        // no gaps or stalls, widest threshold, zero steps
        calm = 1'b1;
        phase_cfg = '{area_left: 0, area_right: 1023, area_top: 0, area_bottom: 1023,
                      move_threshold: 255, target_step: 0, angle_step: 0};
        apply_cfg(phase_cfg, 1'b0);
        run_random(200);
        wait_idle();
        calm = 1'b0;

        apply_cfg(random_cfg(), 1'b1);
        run_random(250);
        wait_idle();
        @(negedge i_clk);

        if (model.errors == 0 && model.pending_turns.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/trkd_pkg.sv
rtl/trkd_cfg.sv
rtl/trkd_core.sv
rtl/touch_ring_knob_decoder_core.sv
rtl/trkd_checker.sv
sim/tb_touch_ring_knob_decoder_core.sv
